[sv/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Modulus value after reset.
  localparam int unsigned MODULUS_RST = 23;

  // Commands from the controller to the datapath, at most one step a cycle.
  typedef struct packed {
    logic load;      // capture base and exponent, seed the running result
    logic red;       // one bit of the base reduction
    logic red_last;  // final reduction bit: latch the reduced base
    logic dbl;       // double both product accumulators
    logic add;       // conditionally add the multiplicands
    logic commit;    // take the products, advance to the next exponent bit
    logic emit;      // move the result into the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } mexp_sts_t;

endpackage

[sv/mexp_if.sv]
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channel interfaces of the modular exponentiation core.
// ----------------------------------------------------------------------------

// Input channel: one beat carries a base and an exponent.
interface mexp_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

// Result channel: one beat carries the power.
interface mexp_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

// Configuration channel: one beat writes the modulus.
interface mexp_cfg_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

[sv/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base ** exponent mod modulus by right-to-left square-and-multiply
// with bit-serial shift-add modular multiplication.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Fields               Beat accepted when
//  --------  ---  -------------------  ----------------------------
//  in_bus    in   base, exponent       in_bus.valid & in_bus.ready
//  out_bus   out  power                out_bus.valid & out_bus.ready
//  cfg_bus   in   modulus              cfg_bus.valid & cfg_bus.ready
//
//  Each exponent bit runs the pair of shift-add modular multipliers (acc*base
//  and base*base side by side), which spend one double step and one add
//  step per multiplier bit; the base reduction before them takes one step
//  per bit of the base.
//  One item is in flight at a time; the next is taken while the previous
//  result still waits in the output register.
//  Reset (synchronous, active low) idles the sequencer, drops any pending
//  result and loads modulus 23. The configuration port never stalls.
//  A stalled output holds the sequencer in its final state until the
//  register frees up.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  mexp_in_if.sink           in_bus,
  mexp_out_if.source        out_bus,
  mexp_cfg_if.sink          cfg_bus
);

  mexp_cmd_t        cmd;
  mexp_sts_t        sts;
  logic [WIDTH-1:0] modulus_q;
  logic             in_acc;

  // Configuration writes land directly in the modulus register.
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;

  // Sequencer: reduce the base, then walk the exponent bits.
  mexp_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and the output register.
  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_base     (in_bus.base),
    .in_exponent (in_bus.exponent),
    .cfg_wr      (cfg_bus.valid),
    .cfg_modulus (cfg_bus.modulus),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .out_power   (out_bus.power),
    .modulus_q   (modulus_q)
  );

  // Once a beat is taken, the block is busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_bus.ready)
    else $error("input accepted again right after a beat");

  // The sequencer issues at most one datapath step per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.red, cmd.dbl, cmd.add, cmd.commit, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // A result is only pushed into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending output beat");

  // Every delivered power lies below a nonzero modulus.
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (modulus_q != '0)) |-> (out_bus.power < modulus_q))
    else $error("power not reduced below modulus");

endmodule

[sv/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: base reduction, then per exponent bit a pair of shift-add
// modular multiplications, then hand-off to the output register.
// ----------------------------------------------------------------------------
module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_DBL    = 6'b000100,
    ST_ADD    = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;    // bit within reduction or multiplication
  logic [CW-1:0] ecnt_r, ecnt_nxt;  // exponent bit
  logic          cnt_last;
  logic          ecnt_last;

  assign cnt_last  = (cnt_r == CW'(WIDTH - 1));
  assign ecnt_last = (ecnt_r == CW'(WIDTH - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ecnt_nxt  = ecnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red = 1'b1;
        if (cnt_last) begin
          cmd.red_last = 1'b1;
          cnt_nxt      = '0;
          ecnt_nxt     = '0;
          state_nxt    = ST_DBL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DBL: begin
        cmd.dbl   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_COMMIT;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_DBL;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (ecnt_last) begin
          state_nxt = ST_DONE;
        end else begin
          ecnt_nxt  = ecnt_r + CW'(1);
          state_nxt = ST_DBL;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ecnt_r  <= ecnt_nxt;
    end
  end

endmodule

[sv/mexp_dp.sv]
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: modulus register, base reduction, two shift-add modular
// multipliers sharing one multiplier bit stream, and the output register.
// ----------------------------------------------------------------------------
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_cmd_t        cmd,
  output mexp_sts_t        sts,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exponent,
  input  logic             cfg_wr,
  input  logic [WIDTH-1:0] cfg_modulus,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_power,
  output logic [WIDTH-1:0] modulus_q
);

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] acc_r;    // running result
  logic [WIDTH-1:0] base_r;   // running base, reduced
  logic [WIDTH-1:0] exp_r;    // exponent, shifted right per bit
  logic [WIDTH-1:0] ysh_r;    // multiplier bits, MSB first
  logic [WIDTH-1:0] red_r;    // partial remainder of the base
  logic [WIDTH-1:0] pa_r;     // acc * base accumulator
  logic [WIDTH-1:0] pb_r;     // base * base accumulator
  logic [WIDTH-1:0] power_r;
  logic             out_valid_r;

  logic [WIDTH-1:0] red_nxt;
  logic [WIDTH-1:0] pa_dbl, pb_dbl, pa_add, pb_add;
  logic [WIDTH-1:0] acc_seed;

  // Bring t below m, given t < 2m.
  function automatic logic [WIDTH-1:0] mod_fix(input logic [WIDTH:0]   t,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] d;
    d = t - {1'b0, m};
    mod_fix = (t >= {1'b0, m}) ? d[WIDTH-1:0] : t[WIDTH-1:0];
  endfunction

  assign red_nxt  = mod_fix({red_r, ysh_r[WIDTH-1]}, mod_r);
  assign pa_dbl   = mod_fix({pa_r, 1'b0}, mod_r);
  assign pb_dbl   = mod_fix({pb_r, 1'b0}, mod_r);
  assign pa_add   = mod_fix({1'b0, pa_r} + {1'b0, acc_r}, mod_r);
  assign pb_add   = mod_fix({1'b0, pb_r} + {1'b0, base_r}, mod_r);
  assign acc_seed = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ysh_r <= in_base;
      exp_r <= in_exponent;
      red_r <= '0;
      acc_r <= acc_seed;
    end
    if (cmd.red) begin
      red_r <= red_nxt;
      if (cmd.red_last) begin
        base_r <= red_nxt;
        ysh_r  <= red_nxt;
        pa_r   <= '0;
        pb_r   <= '0;
      end else begin
        ysh_r <= {ysh_r[WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.dbl) begin
      pa_r <= pa_dbl;
      pb_r <= pb_dbl;
    end
    if (cmd.add) begin
      ysh_r <= {ysh_r[WIDTH-2:0], 1'b0};
      if (ysh_r[WIDTH-1]) begin
        pa_r <= pa_add;
        pb_r <= pb_add;
      end
    end
    if (cmd.commit) begin
      if (exp_r[0]) begin
        acc_r <= pa_r;
      end
      base_r <= pb_r;
      ysh_r  <= pb_r;
      pa_r   <= '0;
      pb_r   <= '0;
      exp_r  <= {1'b0, exp_r[WIDTH-1:1]};
    end
    if (cmd.emit) begin
      power_r <= (mod_r == '0) ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= WIDTH'(MODULUS_RST);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mod_r <= cfg_modulus;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_power    = power_r;
  assign modulus_q    = mod_r;

endmodule
